[rtl/bfc_pkg.sv]
package bfc_pkg;

  localparam int COORD_W   = 24;
  localparam int COLOR_W   = 32;
  localparam int CNT_W     = 7;
  // power-basis coefficients of a curve, signed
  localparam int COEF_W    = 28;
  // quotient width of the mixed-radix forward differences
  localparam int Q_W       = 32;
  // long division retires this many quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_CYC   = Q_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  typedef struct packed {
    logic load;
    logic setup0;
    logic setup1;
    logic setup2;
    logic div_start;
    logic div_step;
    logic div_fix;
    logic prep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } stat_t;

endpackage

[rtl/bezier_curve_flattener.sv]
// a new curve is taken only in idle, after the last segment of the previous curve is emitted
// the long division retires 4 quotient bits a cycle, and the forward-difference stepper
// then emits one segment a cycle while the output is not stalled
// reset: synchronous, active low; clears the sequencer and the output valid
module bezier_curve_flattener #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bfc_pkg::coord_t              in_start_x,
  input  bfc_pkg::coord_t              in_start_y,
  input  bfc_pkg::coord_t              in_ctrl_a_x,
  input  bfc_pkg::coord_t              in_ctrl_a_y,
  input  bfc_pkg::coord_t              in_ctrl_b_x,
  input  bfc_pkg::coord_t              in_ctrl_b_y,
  input  bfc_pkg::coord_t              in_end_x,
  input  bfc_pkg::coord_t              in_end_y,
  input  logic [bfc_pkg::CNT_W-1:0]    in_segment_count,
  input  logic                         in_is_cubic,
  input  logic [bfc_pkg::COLOR_W-1:0]  in_color_rgba,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bfc_pkg::coord_t              out_from_x,
  output bfc_pkg::coord_t              out_from_y,
  output bfc_pkg::coord_t              out_to_x,
  output bfc_pkg::coord_t              out_to_y,
  output logic [bfc_pkg::COLOR_W-1:0]  out_seg_color,
  output logic                         out_last_segment
);

  bfc_pkg::cmd_t  cmd;
  bfc_pkg::stat_t stat;

  bfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfc_dp #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_ctrl_a_x      (in_ctrl_a_x),
    .in_ctrl_a_y      (in_ctrl_a_y),
    .in_ctrl_b_x      (in_ctrl_b_x),
    .in_ctrl_b_y      (in_ctrl_b_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_segment_count (in_segment_count),
    .in_is_cubic      (in_is_cubic),
    .in_color_rgba    (in_color_rgba),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_from_x       (out_from_x),
    .out_from_y       (out_from_y),
    .out_to_x         (out_to_x),
    .out_to_y         (out_to_y),
    .out_seg_color    (out_seg_color),
    .out_last_segment (out_last_segment)
  );

endmodule

[rtl/bfc_div.sv]
module bfc_div #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                                   clk,
  input  logic                                                   start,
  input  logic                                                   step,
  input  logic                                                   fix,
  input  logic signed [bfc_pkg::COEF_W+2*$clog2(MAX_SEGMENTS+1)+5:0] num,
  input  logic [3*$clog2(MAX_SEGMENTS+1)-1:0]                     den,
  output logic signed [bfc_pkg::Q_W-1:0]                          q,
  output logic [3*$clog2(MAX_SEGMENTS+1)-1:0]                     r
);

  localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int DEN_W = 3 * N_W;
  localparam int SW    = bfc_pkg::COEF_W + 2 * N_W + 6;
  localparam int REM_W = DEN_W + 1;
  localparam int QW    = bfc_pkg::Q_W;

  logic              neg_r;
  logic [SW-1:0]     mag;
  logic [QW-1:0]     lo_r, lo_nxt;
  logic [QW-1:0]     qm_r, qm_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  rm;
  logic              rz;
  logic signed [QW-1:0] q_fix, q_r;
  logic [DEN_W-1:0]  r_fix, r_r;

  assign mag = num[SW-1] ? unsigned'(-num) : unsigned'(num);

  // restoring long division on the magnitude, a few bits per cycle
  always_comb begin
    lo_nxt  = lo_r;
    rem_nxt = rem_r;
    qm_nxt  = qm_r;
    for (int j = 0; j < bfc_pkg::DIV_BITS; j++) begin
      rem_nxt = {rem_nxt[REM_W-2:0], lo_nxt[QW-1]};
      lo_nxt  = {lo_nxt[QW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, den}) begin
        rem_nxt = rem_nxt - {1'b0, den};
        qm_nxt  = {qm_nxt[QW-2:0], 1'b1};
      end else begin
        qm_nxt  = {qm_nxt[QW-2:0], 1'b0};
      end
    end
  end

  // turn into floor quotient with remainder in [0, den)
  assign rm    = rem_r[DEN_W-1:0];
  assign rz    = (rm == '0);
  assign q_fix = !neg_r ? signed'(qm_r) : (rz ? -signed'(qm_r) : ~signed'(qm_r));
  assign r_fix = (neg_r && !rz) ? den - rm : rm;

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[SW-1];
      rem_r <= REM_W'(mag >> QW);
      lo_r  <= mag[QW-1:0];
    end else if (step) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      qm_r  <= qm_nxt;
    end
    if (fix) begin
      q_r <= q_fix;
      r_r <= r_fix;
    end
  end

  assign q = q_r;
  assign r = r_r;

endmodule

[rtl/bfc_ctrl.sv]
module bfc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bfc_pkg::stat_t  stat,
  output bfc_pkg::cmd_t   cmd
);

  localparam int CW = bfc_pkg::DIV_CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET0,
    ST_SET1,
    ST_SET2,
    ST_DSTART,
    ST_DIV,
    ST_FIX,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && in_valid;
    cmd.setup0    = (state_r == ST_SET0);
    cmd.setup1    = (state_r == ST_SET1);
    cmd.setup2    = (state_r == ST_SET2);
    cmd.div_start = (state_r == ST_DSTART);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.div_fix   = (state_r == ST_FIX);
    cmd.prep      = (state_r == ST_PREP);
    cmd.emit      = (state_r == ST_EMIT) && stat.out_free;
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SET0;
      ST_SET0:   state_nxt = ST_SET1;
      ST_SET1:   state_nxt = ST_SET2;
      ST_SET2:   state_nxt = ST_DSTART;
      ST_DSTART: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(bfc_pkg::DIV_CYC - 1)) state_nxt = ST_FIX;
      end
      ST_FIX:    state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_EMIT;
      ST_EMIT:   if (cmd.emit && stat.last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // quotients are only fixed up after the full division sweep
  a_fix_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIX |-> $past(state_r) == ST_DIV
      && $past(cnt_r) == CW'(bfc_pkg::DIV_CYC - 1))
    else $error("fixup without completed division");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !cmd.emit && !cmd.div_step && !cmd.prep)
    else $error("datapath commanded while idle");

endmodule

[rtl/bfc_dp.sv]
module bfc_dp #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bfc_pkg::cmd_t                    cmd,
  output bfc_pkg::stat_t                   stat,
  input  bfc_pkg::coord_t                  in_start_x,
  input  bfc_pkg::coord_t                  in_start_y,
  input  bfc_pkg::coord_t                  in_ctrl_a_x,
  input  bfc_pkg::coord_t                  in_ctrl_a_y,
  input  bfc_pkg::coord_t                  in_ctrl_b_x,
  input  bfc_pkg::coord_t                  in_ctrl_b_y,
  input  bfc_pkg::coord_t                  in_end_x,
  input  bfc_pkg::coord_t                  in_end_y,
  input  logic [bfc_pkg::CNT_W-1:0]        in_segment_count,
  input  logic                             in_is_cubic,
  input  logic [bfc_pkg::COLOR_W-1:0]      in_color_rgba,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bfc_pkg::coord_t                  out_from_x,
  output bfc_pkg::coord_t                  out_from_y,
  output bfc_pkg::coord_t                  out_to_x,
  output bfc_pkg::coord_t                  out_to_y,
  output logic [bfc_pkg::COLOR_W-1:0]      out_seg_color,
  output logic                             out_last_segment
);

  localparam int N_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int DEN_W  = 3 * N_W;
  localparam int CW     = bfc_pkg::COEF_W;
  localparam int SW     = CW + 2 * N_W + 6;
  localparam int QW     = bfc_pkg::Q_W;
  localparam int CNT_W  = bfc_pkg::CNT_W;
  localparam int CRD_W  = bfc_pkg::COORD_W;
  localparam logic signed [QW-1:0] QMAX = QW'(bfc_pkg::COORD_MAX);
  localparam logic signed [QW-1:0] QMIN = QW'(bfc_pkg::COORD_MIN);

  // value = q * den + r with 0 <= r < den
  typedef struct packed {
    logic signed [QW-1:0] q;
    logic [DEN_W-1:0]     r;
  } mixed_t;

  function automatic mixed_t madd(mixed_t a, mixed_t b, logic [DEN_W-1:0] d);
    logic [DEN_W:0] rs;
    logic           carry;
    mixed_t         res;
    rs    = {1'b0, a.r} + {1'b0, b.r};
    carry = (rs >= {1'b0, d});
    res.r = carry ? DEN_W'(rs - {1'b0, d}) : rs[DEN_W-1:0];
    res.q = a.q + b.q + $signed({{(QW-1){1'b0}}, carry});
    return res;
  endfunction

  bfc_pkg::coord_t              pt_r [2][4];
  logic [bfc_pkg::COLOR_W-1:0]  color_r;
  logic                         cubic_r;
  logic [N_W-1:0]               n_r, n_in;
  logic [2*N_W-1:0]             n2_r, n2_nxt, n_sel;
  logic [DEN_W-1:0]             n3, den_r;
  logic [N_W-1:0]               seg_r;
  logic                         last;
  bfc_pkg::coord_t              to_val [2];
  bfc_pkg::coord_t              from_r [2];
  logic [DEN_W-1:0]             acc_rem [2];

  logic                         out_valid_r;
  bfc_pkg::coord_t              out_from_x_r, out_from_y_r, out_to_x_r, out_to_y_r;
  logic [bfc_pkg::COLOR_W-1:0]  out_seg_color_r;
  logic                         out_last_segment_r;

  always_comb begin
    if (in_segment_count == '0) begin
      n_in = N_W'(1);
    end else if (in_segment_count > CNT_W'(MAX_SEGMENTS)) begin
      n_in = N_W'(MAX_SEGMENTS);
    end else begin
      n_in = N_W'(in_segment_count);
    end
  end

  assign n2_nxt = n_r * n_r;
  assign n3     = n2_r * n_r;
  assign n_sel  = cubic_r ? n2_r : {{N_W{1'b0}}, n_r};
  assign last   = (seg_r == n_r - N_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_r[0][0] <= in_start_x;
      pt_r[1][0] <= in_start_y;
      pt_r[0][1] <= in_ctrl_a_x;
      pt_r[1][1] <= in_ctrl_a_y;
      pt_r[0][2] <= in_ctrl_b_x;
      pt_r[1][2] <= in_ctrl_b_y;
      pt_r[0][3] <= in_end_x;
      pt_r[1][3] <= in_end_y;
      color_r    <= in_color_rgba;
      cubic_r    <= in_is_cubic;
      n_r        <= n_in;
    end
    if (cmd.setup0) n2_r <= n2_nxt;
    if (cmd.setup1) den_r <= cubic_r ? n3 : DEN_W'(n2_r);
    if (cmd.prep) begin
      seg_r <= '0;
    end else if (cmd.emit) begin
      seg_r <= seg_r + N_W'(1);
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [CW-1:0]      e0, e1, e2, e3, d10, s2, t12;
    logic signed [CW-1:0]      k3s_r, k2s_r, k1s_r;
    logic signed [CW+N_W:0]    m2;
    logic signed [CW+2*N_W:0]  m1;
    logic signed [SW-1:0]      k3_r, k2_r, k1_r;
    logic signed [SW-1:0]      num_r [3];
    logic signed [QW-1:0]      lq [3];
    logic [DEN_W-1:0]          lr [3];
    mixed_t                    src_p, src_1, src_2, src_3;
    mixed_t                    p_nxt, d1_nxt, d2_nxt, p_r, d1_r, d2_r;
    logic                      up;
    logic signed [QW-1:0]      rv;
    bfc_pkg::coord_t           sat;

    assign e0  = CW'(pt_r[a][0]);
    assign e1  = CW'(pt_r[a][1]);
    assign e2  = CW'(pt_r[a][2]);
    assign e3  = CW'(pt_r[a][3]);
    assign d10 = e1 - e0;
    assign s2  = e0 - (e1 <<< 1) + e2;
    assign t12 = e1 - e2;

    assign m2 = k2s_r * $signed({1'b0, n_r});
    assign m1 = k1s_r * $signed({1'b0, n_sel});

    // curve as k3*i^3 + k2*i^2 + k1*i + p0*den, then its forward differences
    always_ff @(posedge clk) begin
      if (cmd.setup0) begin
        if (cubic_r) begin
          k3s_r <= e3 - e0 + t12 + (t12 <<< 1);
          k2s_r <= s2 + (s2 <<< 1);
          k1s_r <= d10 + (d10 <<< 1);
        end else begin
          k3s_r <= '0;
          k2s_r <= e0 - (e1 <<< 1) + e3;
          k1s_r <= d10 <<< 1;
        end
      end
      if (cmd.setup1) begin
        k3_r <= SW'(k3s_r);
        k2_r <= cubic_r ? SW'(m2) : SW'(k2s_r);
        k1_r <= SW'(m1);
      end
      if (cmd.setup2) begin
        num_r[0] <= k3_r + k2_r + k1_r;
        num_r[1] <= (k3_r <<< 2) + (k3_r <<< 1) + (k2_r <<< 1);
        num_r[2] <= (k3_r <<< 2) + (k3_r <<< 1);
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      bfc_div #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
      ) u_div (
        .clk   (clk),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .fix   (cmd.div_fix),
        .num   (num_r[l]),
        .den   (den_r),
        .q     (lq[l]),
        .r     (lr[l])
      );
    end

    always_comb begin
      if (cmd.prep) begin
        src_p.q = QW'(pt_r[a][0]);
        src_p.r = '0;
        src_1.q = lq[0];
        src_1.r = lr[0];
        src_2.q = lq[1];
        src_2.r = lr[1];
      end else begin
        src_p = p_r;
        src_1 = d1_r;
        src_2 = d2_r;
      end
      src_3.q = lq[2];
      src_3.r = lr[2];
    end

    assign p_nxt  = madd(src_p, src_1, den_r);
    assign d1_nxt = madd(src_1, src_2, den_r);
    assign d2_nxt = madd(src_2, src_3, den_r);

    always_ff @(posedge clk) begin
      if (cmd.prep || cmd.emit) begin
        p_r  <= p_nxt;
        d1_r <= d1_nxt;
        d2_r <= d2_nxt;
      end
      if (cmd.prep) begin
        from_r[a] <= pt_r[a][0];
      end else if (cmd.emit) begin
        from_r[a] <= to_val[a];
      end
    end

    // round half away from zero from the floor form
    assign up = p_r.q[QW-1] ? ({p_r.r, 1'b0} > {1'b0, den_r})
                            : ({p_r.r, 1'b0} >= {1'b0, den_r});
    assign rv = p_r.q + $signed({{(QW-1){1'b0}}, up});

    always_comb begin
      if (rv > QMAX) begin
        sat = bfc_pkg::COORD_MAX;
      end else if (rv < QMIN) begin
        sat = bfc_pkg::COORD_MIN;
      end else begin
        sat = rv[CRD_W-1:0];
      end
    end

    assign to_val[a]  = last ? pt_r[a][3] : sat;
    assign acc_rem[a] = p_r.r;
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.last     = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_from_x_r       <= from_r[0];
      out_from_y_r       <= from_r[1];
      out_to_x_r         <= to_val[0];
      out_to_y_r         <= to_val[1];
      out_seg_color_r    <= color_r;
      out_last_segment_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_from_x       = out_from_x_r;
  assign out_from_y       = out_from_y_r;
  assign out_to_x         = out_to_x_r;
  assign out_to_y         = out_to_y_r;
  assign out_seg_color    = out_seg_color_r;
  assign out_last_segment = out_last_segment_r;

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (acc_rem[0] < den_r) && (acc_rem[1] < den_r))
    else $error("point remainder out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && stat.last |=> out_valid_r && out_last_segment_r)
    else $error("final segment not flagged");

endmodule

[sim/bezier_curve_flattener_test.sv]
module bezier_curve_flattener_test;

  localparam int SEGMENT_LIMIT = 64;
  localparam int CNT_W = bfc_pkg::CNT_W;
  localparam int COLOR_W = bfc_pkg::COLOR_W;

  typedef bfc_pkg::coord_t coord_t;

  localparam coord_t COORD_MAX = bfc_pkg::COORD_MAX;
  localparam coord_t COORD_MIN = bfc_pkg::COORD_MIN;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_a_x;
    coord_t ctrl_a_y;
    coord_t ctrl_b_x;
    coord_t ctrl_b_y;
    coord_t end_x;
    coord_t end_y;
    logic [CNT_W-1:0] segment_count;
    logic is_cubic;
    logic [COLOR_W-1:0] color;
  } curve_t;

  typedef struct packed {
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    logic [COLOR_W-1:0] color;
    logic last;
  } segment_t;

  class segment_scoreboard;
    segment_t expected_segments[$];
    int errors;
    int seg_limit;

    function new(int limit);
      seg_limit = limit;
      errors = 0;
    endfunction

    // bernstein sum over exact integer weights, rounded half away from zero
    function longint curve_coord(longint p0, longint p1, longint p2, longint p3,
                                 bit cubic, longint n, longint i);
      longint u, num, den, mag, q;
      if (i >= n) return p3;
      u = n - i;
      if (cubic) begin
        num = u * u * u * p0 + 3 * u * u * i * p1 + 3 * u * i * i * p2 + i * i * i * p3;
        den = n * n * n;
      end else begin
        num = u * u * p0 + 2 * u * i * p1 + i * i * p3;
        den = n * n;
      end
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      if (q > COORD_MAX) q = COORD_MAX;
      if (q < COORD_MIN) q = COORD_MIN;
      return q;
    endfunction

    function void note_curve(curve_t c);
      longint n, k, fx, fy, tx, ty;
      segment_t s;
      n = c.segment_count;
      if (n == 0) n = 1;
      if (n > seg_limit) n = seg_limit;
      fx = c.start_x;
      fy = c.start_y;
      for (k = 1; k <= n; k++) begin
        tx = curve_coord(c.start_x, c.ctrl_a_x, c.ctrl_b_x, c.end_x, c.is_cubic, n, k);
        ty = curve_coord(c.start_y, c.ctrl_a_y, c.ctrl_b_y, c.end_y, c.is_cubic, n, k);
        s.from_x = coord_t'(fx);
        s.from_y = coord_t'(fy);
        s.to_x = coord_t'(tx);
        s.to_y = coord_t'(ty);
        s.color = c.color;
        s.last = (k == n);
        expected_segments.push_back(s);
        fx = tx;
        fy = ty;
      end
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (expected_segments.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("error: segment (%0d,%0d)->(%0d,%0d) color %h last %b with none pending",
                   got.from_x, got.from_y, got.to_x, got.to_y, got.color, got.last);
        return;
      end
      want = expected_segments.pop_front();
      if (got.from_x !== want.from_x || got.from_y !== want.from_y ||
          got.to_x !== want.to_x || got.to_y !== want.to_y ||
          got.color !== want.color || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("error: expected (%0d,%0d)->(%0d,%0d) %h %b, got (%0d,%0d)->(%0d,%0d) %h %b",
                   want.from_x, want.from_y, want.to_x, want.to_y, want.color, want.last,
                   got.from_x, got.from_y, got.to_x, got.to_y, got.color, got.last);
      end
    endfunction

    function int pending();
      return expected_segments.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_ctrl_a_x = '0;
  coord_t in_ctrl_a_y = '0;
  coord_t in_ctrl_b_x = '0;
  coord_t in_ctrl_b_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic [CNT_W-1:0] in_segment_count = '0;
  logic in_is_cubic = 1'b0;
  logic [COLOR_W-1:0] in_color_rgba = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_from_x;
  coord_t out_from_y;
  coord_t out_to_x;
  coord_t out_to_y;
  logic [COLOR_W-1:0] out_seg_color;
  logic out_last_segment;

  int idle_pct = 0;
  int stall_pct = 0;
  segment_t seen_segment;
  segment_scoreboard sb = new(SEGMENT_LIMIT);

  bezier_curve_flattener #(.MAX_SEGMENTS(SEGMENT_LIMIT)) uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_segment.from_x = out_from_x;
      seen_segment.from_y = out_from_y;
      seen_segment.to_x = out_to_x;
      seen_segment.to_y = out_to_y;
      seen_segment.color = out_seg_color;
      seen_segment.last = out_last_segment;
      sb.check_segment(seen_segment);
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  function automatic curve_t make_curve(coord_t sx, coord_t sy, coord_t ax, coord_t ay,
                                        coord_t bx, coord_t by, coord_t ex, coord_t ey,
                                        logic [CNT_W-1:0] cnt, logic cubic,
                                        logic [COLOR_W-1:0] color);
    curve_t c;
    c.start_x = sx;
    c.start_y = sy;
    c.ctrl_a_x = ax;
    c.ctrl_a_y = ay;
    c.ctrl_b_x = bx;
    c.ctrl_b_y = by;
    c.end_x = ex;
    c.end_y = ey;
    c.segment_count = cnt;
    c.is_cubic = cubic;
    c.color = color;
    return c;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'($urandom_range(0, 1023) - 512);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.start_x = random_coord();
    c.start_y = random_coord();
    c.ctrl_a_x = random_coord();
    c.ctrl_a_y = random_coord();
    c.ctrl_b_x = random_coord();
    c.ctrl_b_y = random_coord();
    c.end_x = random_coord();
    c.end_y = random_coord();
    // mostly short curves, a few full length and over the limit
    if (pick < 70) c.segment_count = $urandom_range(0, 8);
    else if (pick < 88) c.segment_count = $urandom_range(9, 63);
    else if (pick < 94) c.segment_count = SEGMENT_LIMIT;
    else c.segment_count = $urandom_range(SEGMENT_LIMIT + 1, 127);
    c.is_cubic = $urandom_range(0, 1);
    c.color = $urandom();
    return c;
  endfunction

  task automatic idle_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic send_curve(curve_t c);
    in_start_x <= c.start_x;
    in_start_y <= c.start_y;
    in_ctrl_a_x <= c.ctrl_a_x;
    in_ctrl_a_y <= c.ctrl_a_y;
    in_ctrl_b_x <= c.ctrl_b_x;
    in_ctrl_b_y <= c.ctrl_b_y;
    in_end_x <= c.end_x;
    in_end_y <= c.end_y;
    in_segment_count <= c.segment_count;
    in_is_cubic <= c.is_cubic;
    in_color_rgba <= c.color;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_curve(c);
    idle_gap();
  endtask

  // hold the sender off until every segment has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_curves(int count);
    for (int i = 0; i < count; i++) send_curve(random_curve());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero count on both curve kinds, then a single segment
    send_curve(make_curve(0, 0, 100, 200, 0, 0, 256, -256, 0, 0, 32'h11223344));
    send_curve(make_curve(-300, 77, 5, 9, -1000, 2000, 4096, 1, 0, 1, 32'h55667788));
    send_curve(make_curve(10, -20, 30, -40, 50, -60, 70, -80, 1, 0, 32'h9abcdef0));
    // rounding ties, positive and negative; quadratic ignores the second control
    send_curve(make_curve(1, -1, 0, 0, 12345, -54321, 1, -1, 2, 0, 32'h00000000));
    send_curve(make_curve(1, -1, 1, -1, 0, 0, 0, 0, 2, 1, 32'hffffffff));
    // extremes at full length and one short of it
    send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, SEGMENT_LIMIT, 1, 32'hffffffff));
    send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN, COORD_MIN, SEGMENT_LIMIT, 0, 32'h00000000));
    send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                          COORD_MIN, COORD_MAX, SEGMENT_LIMIT, 1, 32'ha5a5a5a5));
    send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                          COORD_MIN, COORD_MAX, 63, 0, 32'h5a5a5a5a));
    // counts over the limit
    send_curve(make_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord(),
                          SEGMENT_LIMIT + 1, 1, $urandom()));
    send_curve(make_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord(),
                          127, 0, $urandom()));
    send_curve(make_curve(-5000, 3000, 8000, -7000, -2000, 9000, 6000, -4000, 100, 1,
                          32'h0f0f0f0f));
    // closed curve, start equals end
    send_curve(make_curve(COORD_MAX, COORD_MIN, 0, 0, 77, 88, COORD_MAX, COORD_MIN, 3, 0,
                          32'hf0f0f0f0));
    send_curve(make_curve(3, -7, 11, 13, -17, 19, 23, -29, 3, 1, 32'h01020304));
    send_curve(make_curve(-256, 512, 768, -1024, 0, 0, 1280, 1536, 7, 0, 32'h80000001));
    send_curve(make_curve(255, -255, -511, 511, 1023, -1023, -2047, 2047, 5, 1,
                          32'h7ffffffe));
    drain();

    random_curves(36);
    drain();
    idle_pct = 84;
    random_curves(36);
    drain();
    idle_pct = 0;
    stall_pct = 84;
    random_curves(36);
    drain();
    idle_pct = 17;
    stall_pct = 17;
    random_curves(36);
    drain();

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS bezier_curve_flattener");
    else
      $display("FAIL bezier_curve_flattener");
    $finish;
  end

  initial begin
    #3200000;
    $display("FAIL bezier_curve_flattener");
    $finish;
  end

endmodule
